>>> rtl/zbhr_pkg.sv
// Shared types and constants for the ZMODEM binary header receiver.
`timescale 1ns / 1ps

package zbhr_pkg;

	// Depth of the queue between the classifying front end and the decoder.
	localparam int unsigned QUEUE_DEPTH = 2;

	// Line characters that matter to the unescaper.
	localparam logic [7:0] ZDLE_CHAR  = 8'h18;
	localparam logic [7:0] ZCRCE_CHAR = 8'h68;
	localparam logic [7:0] ZRUB0_CHAR = 8'h6C;
	localparam logic [7:0] ZRUB1_CHAR = 8'h6D;
	localparam logic [7:0] XON_CHAR   = 8'h11;
	localparam logic [7:0] XOFF_CHAR  = 8'h13;
	localparam logic [7:0] XON_PAR    = 8'h91;
	localparam logic [7:0] XOFF_PAR   = 8'h93;

	localparam logic [31:0] CRC32_INIT    = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC32_RESIDUE = 32'hDEBB_20E3;
	localparam logic [31:0] CRC32_POLY    = 32'hEDB8_8320;
	localparam logic [15:0] CRC16_POLY    = 16'h1021;

	// Header length in decoded bytes: type, four position bytes, then the CRC.
	localparam logic [3:0] LEN_CRC16 = 4'd7;
	localparam logic [3:0] LEN_CRC32 = 4'd9;

	// Input mode codes.
	localparam logic [1:0] MODE_BYTE    = 2'd0;
	localparam logic [1:0] MODE_BEGIN16 = 2'd1;
	localparam logic [1:0] MODE_BEGIN32 = 2'd2;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_BAD_CRC = 3'd1,
		ST_TIMEOUT = 3'd2,
		ST_CANCEL  = 3'd3,
		ST_BAD_ESC = 3'd4,
		ST_FRAME_END = 3'd5
	} status_t;

	// What the front end saw in one transaction.
	typedef enum logic [2:0] {
		CMD_NOP     = 3'd0,
		CMD_BEGIN16 = 3'd1,
		CMD_BEGIN32 = 3'd2,
		CMD_TIMEOUT = 3'd3,
		CMD_BYTE    = 3'd4
	} cmd_t;

	// Meaning of a line byte when no escape is pending.
	typedef enum logic [1:0] {
		PLAIN_ZDLE = 2'd0,
		PLAIN_DROP = 2'd1,
		PLAIN_DATA = 2'd2
	} plain_cls_t;

	// Meaning of a line byte that follows a ZDLE.
	typedef enum logic [2:0] {
		ESC_CAN  = 3'd0,
		ESC_END  = 3'd1,
		ESC_DATA = 3'd2,
		ESC_DROP = 3'd3,
		ESC_BAD  = 3'd4
	} esc_cls_t;

	typedef struct packed {
		cmd_t       cmd;
		plain_cls_t plain_cls;
		esc_cls_t   esc_cls;
		logic [7:0] raw;
		logic [7:0] esc_data;
		logic [1:0] marker;
	} entry_t;

endpackage

>>> rtl/zmodem_binary_header_receiver.sv
// Top level of the ZMODEM binary header receiver: front end, queue and back end.
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// cfg       cfg_valid/cfg_ready    cfg_data (escape_ctl)
// in        in_valid/in_ready      mode, line_byte, timed_out
// out       out_valid/out_ready    status, header_type, position, end_marker
//
// Each input transaction is classified in the cycle it is accepted and queued;
// the back end decodes one queued entry per cycle while the output flows, so
// one transaction per cycle is sustained. The closing byte passes through the
// queue and then the result register before its result is offered, and a
// stalled output keeps the result waiting there. The rate is set by the CRC
// byte update in the back end, which is combinational. Reset is asynchronous
// and clears the register, the queue and all header state. A stalled output
// only holds the back end; the front end keeps accepting until the queue is full.

module zmodem_binary_header_receiver
	import zbhr_pkg::*;
#(
	parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [7:0]  line_byte,
	input  logic        timed_out,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [7:0]  header_type,
	output logic [31:0] position,
	output logic [1:0]  end_marker
);

	entry_t front_entry;
	entry_t head;
	logic   q_full;
	logic   q_empty;
	logic   pop;
	logic   push;

	// The queue absorbs transactions while the result register waits.
	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	zbhr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.mode      (mode),
		.line_byte (line_byte),
		.timed_out (timed_out),
		.entry     (front_entry)
	);

	zbhr_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (front_entry),
		.full       (q_full),
		.pop        (pop),
		.empty      (q_empty),
		.head       (head)
	);

	// The back end holds the escape state and the running CRC, and registers
	// the result so that a stalled consumer never loses a report.
	zbhr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (q_empty),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.header_type (header_type),
		.position    (position),
		.end_marker  (end_marker)
	);

endmodule

>>> rtl/zbhr_front.sv
// Front end: holds the escape_ctl register and classifies each line transaction.
`timescale 1ns / 1ps

module zbhr_front
	import zbhr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,
	input  logic [1:0] mode,
	input  logic [7:0] line_byte,
	input  logic       timed_out,
	output entry_t     entry
);

	logic escape_ctl_q;
	logic is_flow;
	logic is_bare;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_ctl_q <= 1'b0;
		end else if (cfg_valid) begin
			escape_ctl_q <= cfg_data;
		end
	end

	assign is_flow = (line_byte == XON_CHAR) || (line_byte == XOFF_CHAR) ||
		(line_byte == XON_PAR) || (line_byte == XOFF_PAR);
	assign is_bare = escape_ctl_q && (line_byte[6:5] == 2'b00);

	always_comb begin
		entry.raw      = line_byte;
		entry.marker   = line_byte[1:0];
		entry.esc_data = line_byte ^ 8'h40;

		if (mode == MODE_BEGIN16) begin
			entry.cmd = CMD_BEGIN16;
		end else if (mode == MODE_BEGIN32) begin
			entry.cmd = CMD_BEGIN32;
		end else if (mode != MODE_BYTE) begin
			entry.cmd = CMD_NOP;
		end else if (timed_out) begin
			entry.cmd = CMD_TIMEOUT;
		end else begin
			entry.cmd = CMD_BYTE;
		end

		if (line_byte == ZDLE_CHAR) begin
			entry.plain_cls = PLAIN_ZDLE;
		end else if (is_flow || is_bare) begin
			entry.plain_cls = PLAIN_DROP;
		end else begin
			entry.plain_cls = PLAIN_DATA;
		end

		// The escape character doubles as CAN, so it is tested first.
		if (line_byte == ZDLE_CHAR) begin
			entry.esc_cls = ESC_CAN;
		end else if (line_byte[7:2] == ZCRCE_CHAR[7:2]) begin
			entry.esc_cls = ESC_END;
		end else if (line_byte == ZRUB0_CHAR) begin
			entry.esc_cls  = ESC_DATA;
			entry.esc_data = 8'h7F;
		end else if (line_byte == ZRUB1_CHAR) begin
			entry.esc_cls  = ESC_DATA;
			entry.esc_data = 8'hFF;
		end else if (is_flow || is_bare) begin
			entry.esc_cls = ESC_DROP;
		end else if (line_byte[6:5] == 2'b10) begin
			entry.esc_cls = ESC_DATA;
		end else begin
			entry.esc_cls = ESC_BAD;
		end
	end

endmodule

>>> rtl/zbhr_queue.sv
// Small first-in first-out queue of classified entries between front and back.
`timescale 1ns / 1ps

module zbhr_queue
	import zbhr_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output logic   empty,
	output entry_t head
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	entry_t        mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == FULL_COUNT);
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/zbhr_back.sv
// Back end: escape state, header assembly, CRC check and the result register.
`timescale 1ns / 1ps

module zbhr_back
	import zbhr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        empty,
	input  entry_t      head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [7:0]  header_type,
	output logic [31:0] position,
	output logic [1:0]  end_marker
);

	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC16_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ({1'b0, c[31:1]} ^ CRC32_POLY) : {1'b0, c[31:1]};
		end
		return c;
	endfunction

	logic        active_q, active_d;
	logic        use_crc32_q, use_crc32_d;
	logic [3:0]  byte_count_q, byte_count_d;
	logic        esc_pending_q, esc_pending_d;
	logic [1:0]  cancel_count_q, cancel_count_d;
	logic [31:0] crc_q, crc_d;
	logic [7:0]  type_q, type_d;
	logic [31:0] pos_q, pos_d;

	logic        have_data;
	logic [7:0]  data;
	logic        fin;
	status_t     fin_status;
	logic [1:0]  fin_marker;
	logic [31:0] crc_upd;
	logic        crc_good;

	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [7:0]  header_type_q;
	logic [31:0] position_q;
	logic [1:0]  end_marker_q;

	// A result register that is free or being emptied lets the next entry in.
	assign pop = !empty && (!out_valid_q || out_ready);

	// After a ZDLE the decoded byte comes from the escape table, otherwise the
	// line byte is taken as it is.
	assign data = esc_pending_q ? head.esc_data : head.raw;

	assign crc_upd = use_crc32_q ? crc32_step(crc_q, data)
		: {16'h0, crc16_step(crc_q[15:0], data)};
	assign crc_good = use_crc32_q ? (crc_upd == CRC32_RESIDUE) : (crc_upd[15:0] == 16'h0);

	always_comb begin
		active_d       = active_q;
		use_crc32_d    = use_crc32_q;
		byte_count_d   = byte_count_q;
		esc_pending_d  = esc_pending_q;
		cancel_count_d = cancel_count_q;
		crc_d          = crc_q;
		type_d         = type_q;
		pos_d          = pos_q;
		have_data      = 1'b0;
		fin            = 1'b0;
		fin_status     = ST_OK;
		fin_marker     = 2'd0;

		if (pop) begin
			unique case (head.cmd)
				CMD_BEGIN16, CMD_BEGIN32: begin
					active_d       = 1'b1;
					use_crc32_d    = (head.cmd == CMD_BEGIN32);
					byte_count_d   = 4'd0;
					esc_pending_d  = 1'b0;
					cancel_count_d = 2'd0;
					crc_d          = (head.cmd == CMD_BEGIN32) ? CRC32_INIT : 32'h0;
					type_d         = 8'h00;
					pos_d          = 32'h0;
				end
				CMD_NOP: begin
				end
				CMD_TIMEOUT: begin
					if (active_q) begin
						fin        = 1'b1;
						fin_status = ST_TIMEOUT;
					end
				end
				CMD_BYTE: begin
					if (active_q && !esc_pending_q) begin
						unique case (head.plain_cls)
							PLAIN_ZDLE: begin
								esc_pending_d  = 1'b1;
								cancel_count_d = 2'd0;
							end
							PLAIN_DROP: begin
							end
							PLAIN_DATA: begin
								have_data = 1'b1;
							end
							default: begin
							end
						endcase
					end else if (active_q) begin
						unique case (head.esc_cls)
							ESC_CAN: begin
								if (cancel_count_q == 2'd3) begin
									fin        = 1'b1;
									fin_status = ST_CANCEL;
								end else begin
									cancel_count_d = cancel_count_q + 2'd1;
								end
							end
							ESC_END: begin
								fin        = 1'b1;
								fin_status = ST_FRAME_END;
								fin_marker = head.marker;
							end
							ESC_DATA: begin
								have_data      = 1'b1;
								esc_pending_d  = 1'b0;
								cancel_count_d = 2'd0;
							end
							ESC_DROP: begin
								cancel_count_d = 2'd0;
							end
							ESC_BAD: begin
								fin        = 1'b1;
								fin_status = ST_BAD_ESC;
							end
							default: begin
							end
						endcase
					end
				end
				default: begin
				end
			endcase

			if (have_data) begin
				crc_d        = crc_upd;
				byte_count_d = byte_count_q + 4'd1;
				unique case (byte_count_q)
					4'd0: type_d = data;
					4'd1: pos_d[7:0]   = data;
					4'd2: pos_d[15:8]  = data;
					4'd3: pos_d[23:16] = data;
					4'd4: pos_d[31:24] = data;
					default: begin
					end
				endcase
				if (byte_count_d >= (use_crc32_q ? LEN_CRC32 : LEN_CRC16)) begin
					fin        = 1'b1;
					fin_status = crc_good ? ST_OK : ST_BAD_CRC;
				end
			end

			if (fin) begin
				active_d       = 1'b0;
				esc_pending_d  = 1'b0;
				cancel_count_d = 2'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q       <= 1'b0;
			use_crc32_q    <= 1'b0;
			byte_count_q   <= 4'd0;
			esc_pending_q  <= 1'b0;
			cancel_count_q <= 2'd0;
			crc_q          <= 32'h0;
			type_q         <= 8'h00;
			pos_q          <= 32'h0;
			out_valid_q    <= 1'b0;
		end else begin
			active_q       <= active_d;
			use_crc32_q    <= use_crc32_d;
			byte_count_q   <= byte_count_d;
			esc_pending_q  <= esc_pending_d;
			cancel_count_q <= cancel_count_d;
			crc_q          <= crc_d;
			type_q         <= type_d;
			pos_q          <= pos_d;
			if (pop && fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && fin) begin
			status_q      <= fin_status;
			header_type_q <= type_d;
			position_q    <= pos_d;
			end_marker_q  <= fin_marker;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign header_type = header_type_q;
	assign position    = position_q;
	assign end_marker  = end_marker_q;

endmodule

>>> dv/tb_zmodem_binary_header_receiver.sv
// Self-checking testbench for the ZMODEM binary header receiver.
`timescale 1ns / 1ps

module tb_zmodem_binary_header_receiver;
	import zbhr_pkg::*;

	// The mode code that the block must ignore, and the cancel character, which shares
	// its code with ZDLE.
	localparam logic [1:0] MODE_IGNORED = 2'd3;
	localparam logic [7:0] CAN_CHAR     = ZDLE_CHAR;

	localparam int QUIET_LIMIT   = 2000;  // cycles with no transaction on any channel
	localparam int SETTLE_CYCLES = 10;    // covers the queue and the back end
	localparam int HOLD_CYCLES   = 80;    // the one long hold-off of the result channel
	localparam int MAX_SHOWN     = 10;
	localparam int CHUNK_ITEMS   = 150;

	// One decoded header report, as the block presents it on the result channel.
	typedef struct packed {
		status_t     status;
		logic [7:0]  htype;
		logic [31:0] pos;
		logic [1:0]  marker;
	} hdr_report_t;

	// One raw transaction on the input channel.
	typedef struct packed {
		logic [1:0] md;
		logic [7:0] b;
		logic       tmo;
	} line_item_t;

	// How a generated header is brought to an end.
	typedef enum {
		END_GOOD, END_BAD_CRC, END_TIMEOUT, END_CANCEL, END_MARKER, END_BAD_ESC, END_ABANDON
	} hdr_end_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  mode = MODE_BYTE;
	logic [7:0]  line_byte = 8'h00;
	logic        timed_out = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [7:0]  header_type;
	logic [31:0] position;
	logic [1:0]  end_marker;

	zmodem_binary_header_receiver u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.line_byte  (line_byte),
		.timed_out  (timed_out),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.header_type(header_type),
		.position   (position),
		.end_marker (end_marker)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Shadow of the block's state, kept by the header decoder below.
	// ------------------------------------------------------------------
	logic        ctl_escaped = 1'b0;
	logic        hdr_active = 1'b0;
	logic        hdr_wide = 1'b0;
	logic [3:0]  hdr_count = '0;
	logic        esc_wait = 1'b0;
	logic [2:0]  can_run = '0;
	logic [31:0] crc_reg = '0;
	logic [7:0]  type_seen = '0;
	logic [31:0] pos_seen = '0;

	hdr_report_t expected_reports [$];
	line_item_t  line_items [$];

	// Bookkeeping shared between the stimulus, the driver and the monitor.
	int    pushed_count = 0;
	int    accepted_count = 0;
	int    err_count = 0;
	int    quiet_cycles = 0;
	int    snd_idle_pct = 0;
	int    rcv_stall_pct = 0;
	int    hold_left = 0;
	bit    hold_req = 1'b0;
	bit    line_taken = 1'b0;
	bit    cfg_taken = 1'b0;
	logic  gen_ctl_escaped = 1'b0;

	hdr_report_t got_report, want_report, next_report;

	function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] d);
		int i;
		c = c ^ {d, 8'h00};
		for (i = 0; i < 8; i++)
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC16_POLY) : {c[14:0], 1'b0};
		return c;
	endfunction

	function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] d);
		int i;
		c = c ^ {24'h0, d};
		for (i = 0; i < 8; i++)
			c = c[0] ? ((c >> 1) ^ CRC32_POLY) : (c >> 1);
		return c;
	endfunction

	// XON and XOFF, with or without the parity bit, are dropped wherever they turn up.
	function automatic bit flow_char(input logic [7:0] b);
		return b == XON_CHAR || b == XOFF_CHAR || b == XON_PAR || b == XOFF_PAR;
	endfunction

	// Any report sends the decoder back to idle; the type and position stay as gathered.
	function automatic bit close_header(input status_t st, input logic [1:0] mk,
			output hdr_report_t r);
		hdr_active = 1'b0;
		esc_wait = 1'b0;
		can_run = '0;
		r.status = st;
		r.htype = type_seen;
		r.pos = pos_seen;
		r.marker = mk;
		return 1'b1;
	endfunction

	// Advances the shadow state by one accepted transaction. Returns 1 with the
	// report in r when that transaction closes a header.
	function automatic bit decode_line_item(input logic [1:0] md, input logic [7:0] b,
			input logic tmo, output hdr_report_t r);
		logic [7:0] data;
		bit good;
		r = '0;
		if (md == MODE_BEGIN16 || md == MODE_BEGIN32) begin
			// A begin always starts afresh, abandoning any header in progress.
			hdr_active = 1'b1;
			hdr_wide = (md == MODE_BEGIN32);
			hdr_count = '0;
			esc_wait = 1'b0;
			can_run = '0;
			crc_reg = hdr_wide ? CRC32_INIT : '0;
			type_seen = '0;
			pos_seen = '0;
			return 1'b0;
		end
		if (md != MODE_BYTE || !hdr_active)
			return 1'b0;
		if (tmo)
			return close_header(ST_TIMEOUT, 2'd0, r);
		if (!esc_wait) begin
			if (b == ZDLE_CHAR) begin
				esc_wait = 1'b1;
				can_run = '0;
				return 1'b0;
			end
			if (flow_char(b) || (ctl_escaped && b[6:5] == 2'b00))
				return 1'b0;
			data = b;
		end else begin
			if (b == CAN_CHAR) begin
				// The fourth CAN after a ZDLE is an abort.
				if (can_run >= 3'd3)
					return close_header(ST_CANCEL, 2'd0, r);
				can_run = can_run + 3'd1;
				return 1'b0;
			end
			// The four frame-end codes are consecutive from ZCRCE, so the low bits
			// number the marker.
			if (b >= ZCRCE_CHAR && b <= ZCRCE_CHAR + 8'd3)
				return close_header(ST_FRAME_END, b[1:0], r);
			if (b == ZRUB0_CHAR) begin
				data = 8'h7F;
			end else if (b == ZRUB1_CHAR) begin
				data = 8'hFF;
			end else if (flow_char(b) || (ctl_escaped && b[6:5] == 2'b00)) begin
				// Noise inside an escape restarts the CAN run but keeps the escape.
				can_run = '0;
				return 1'b0;
			end else if (b[6:5] == 2'b10) begin
				data = b ^ 8'h40;
			end else begin
				return close_header(ST_BAD_ESC, 2'd0, r);
			end
			esc_wait = 1'b0;
			can_run = '0;
		end
		if (hdr_wide)
			crc_reg = crc32_step(crc_reg, data);
		else
			crc_reg = {16'h0000, crc16_step(crc_reg[15:0], data)};
		if (hdr_count == 4'd0)
			type_seen = data;
		else if (hdr_count <= 4'd4)
			pos_seen[8 * (int'(hdr_count) - 1) +: 8] = data;
		hdr_count = hdr_count + 4'd1;
		if (hdr_count >= (hdr_wide ? LEN_CRC32 : LEN_CRC16)) begin
			good = hdr_wide ? (crc_reg == CRC32_RESIDUE) : (crc_reg[15:0] == 16'h0000);
			return close_header(good ? ST_OK : ST_BAD_CRC, 2'd0, r);
		end
		return 1'b0;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus generation. Everything here only fills the queue of pending
	// transactions; the driver below paces them onto the input channel.
	// ------------------------------------------------------------------
	task automatic push_item(input logic [1:0] md, input logic [7:0] b, input logic tmo);
		line_item_t it;
		it.md = md;
		it.b = b;
		it.tmo = tmo;
		line_items.push_back(it);
		pushed_count++;
	endtask

	// Now and then a flow-control character, or a bare control character when those
	// are meant to arrive escaped, is slipped into the line; both are to be dropped.
	task automatic maybe_noise();
		int p;
		logic [7:0] c;
		p = $urandom_range(0, 99);
		if (p < 6) begin
			case ($urandom_range(0, 3))
				0: c = XON_CHAR;
				1: c = XOFF_CHAR;
				2: c = XON_PAR;
				default: c = XOFF_PAR;
			endcase
			push_item(MODE_BYTE, c, 1'b0);
		end else if (p < 11 && gen_ctl_escaped) begin
			do
				c = {1'($urandom), 2'b00, 5'($urandom)};
			while (c == ZDLE_CHAR);
			push_item(MODE_BYTE, c, 1'b0);
		end
	endtask

	// Puts one decoded header byte on the line, escaping it where it must be and
	// sometimes where it need not be.
	task automatic push_data(input logic [7:0] d);
		bit escapable, must;
		maybe_noise();
		escapable = (d[6:5] == 2'b00);
		must = (d == ZDLE_CHAR) || flow_char(d) || (gen_ctl_escaped && escapable);
		if ((d == 8'h7F || d == 8'hFF) && $urandom_range(0, 1) == 1) begin
			push_item(MODE_BYTE, ZDLE_CHAR, 1'b0);
			maybe_noise();
			push_item(MODE_BYTE, d[7] ? ZRUB1_CHAR : ZRUB0_CHAR, 1'b0);
		end else if (must || (escapable && $urandom_range(0, 4) == 0)) begin
			push_item(MODE_BYTE, ZDLE_CHAR, 1'b0);
			// A short run of CANs that does not reach an abort is simply consumed.
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(1, 3)) push_item(MODE_BYTE, CAN_CHAR, 1'b0);
			maybe_noise();
			push_item(MODE_BYTE, d ^ 8'h40, 1'b0);
		end else begin
			push_item(MODE_BYTE, d, 1'b0);
		end
	endtask

	// A begin, then the header body and CRC, cut short or corrupted as asked.
	task automatic push_header(input bit wide, input hdr_end_t how, input logic [7:0] htype,
			input logic [31:0] pos);
		logic [7:0] body [0:8];
		logic [31:0] crc;
		logic [7:0] esc;
		int len, cut, i;
		len = wide ? int'(LEN_CRC32) : int'(LEN_CRC16);
		push_item(wide ? MODE_BEGIN32 : MODE_BEGIN16, 8'($urandom), 1'($urandom));
		body[0] = htype;
		for (i = 0; i < 4; i++)
			body[i + 1] = pos[8 * i +: 8];
		if (wide) begin
			crc = CRC32_INIT;
			for (i = 0; i < 5; i++)
				crc = crc32_step(crc, body[i]);
			crc = ~crc;
			for (i = 0; i < 4; i++)
				body[5 + i] = crc[8 * i +: 8];
		end else begin
			crc = '0;
			for (i = 0; i < 5; i++)
				crc[15:0] = crc16_step(crc[15:0], body[i]);
			body[5] = crc[15:8];
			body[6] = crc[7:0];
		end
		if (how == END_BAD_CRC) begin
			i = $urandom_range(0, len - 1);
			body[i] = body[i] ^ (8'h01 << $urandom_range(0, 7));
		end
		cut = (how == END_GOOD || how == END_BAD_CRC) ? len : $urandom_range(0, len - 1);
		for (i = 0; i < cut; i++)
			push_data(body[i]);
		case (how)
			END_TIMEOUT: push_item(MODE_BYTE, 8'($urandom), 1'b1);
			END_CANCEL: begin
				push_item(MODE_BYTE, ZDLE_CHAR, 1'b0);
				repeat (4) push_item(MODE_BYTE, CAN_CHAR, 1'b0);
			end
			END_MARKER: begin
				push_item(MODE_BYTE, ZDLE_CHAR, 1'b0);
				push_item(MODE_BYTE, ZCRCE_CHAR + 8'($urandom_range(0, 3)), 1'b0);
			end
			END_BAD_ESC: begin
				// Anything after a ZDLE that is neither a CAN, a marker, a rubout code,
				// droppable noise nor a byte with bits 6..5 at 10.
				do
					esc = 8'($urandom);
				while (esc[6:5] == 2'b10 || esc == CAN_CHAR || flow_char(esc) ||
					(esc >= ZCRCE_CHAR && esc <= ZRUB1_CHAR) ||
					(gen_ctl_escaped && esc[6:5] == 2'b00));
				push_item(MODE_BYTE, ZDLE_CHAR, 1'b0);
				push_item(MODE_BYTE, esc, 1'b0);
			end
			// The half-finished header is left for the next begin to abandon.
			END_ABANDON: push_item(MODE_IGNORED, 8'($urandom), 1'($urandom));
			default: ;
		endcase
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 11))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h7F;
			3: return ZDLE_CHAR;
			4: return XON_CHAR;
			5: return XOFF_PAR;
			6: return 8'h0D;
			default: return 8'($urandom);
		endcase
	endfunction

	// Mostly well-formed headers with random content, the rest broken headers and
	// completely random transactions.
	task automatic push_random_traffic(input int n_items);
		int first, p;
		hdr_end_t how;
		first = pushed_count;
		while (pushed_count - first < n_items) begin
			p = $urandom_range(0, 99);
			if (p < 5) begin
				push_item(2'($urandom), 8'($urandom), 1'($urandom));
			end else begin
				p = $urandom_range(0, 99);
				how = p < 55 ? END_GOOD : p < 67 ? END_BAD_CRC : p < 74 ? END_TIMEOUT :
					p < 81 ? END_CANCEL : p < 88 ? END_MARKER : p < 95 ? END_BAD_ESC :
					END_ABANDON;
				push_header(1'($urandom), how, pick_byte(),
					{pick_byte(), pick_byte(), pick_byte(), pick_byte()});
			end
		end
	endtask

	// Waits until every pending transaction has gone in and every expected report
	// has come out, then gives the queue and the back end time to empty.
	task automatic settle_block();
		do
			@(negedge clk);
		while (accepted_count != pushed_count || expected_reports.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_escape_ctl(input logic v);
		@(negedge clk);
		cfg_taken = 1'b0;
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do
			@(negedge clk);
		while (!cfg_taken);
		cfg_valid <= 1'b0;
		gen_ctl_escaped = v;
	endtask

	// ------------------------------------------------------------------
	// Input driver: presents the next pending transaction at the falling edge,
	// holding it steady until the monitor has seen it accepted.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		line_item_t it;
		if (arst_n && !(in_valid && !line_taken)) begin
			line_taken = 1'b0;
			if (line_items.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
				it = line_items.pop_front();
				mode <= it.md;
				line_byte <= it.b;
				timed_out <= it.tmo;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result channel back-pressure. A hold-off request makes the receiver refuse
	// reports for a long stretch while the sender carries on, so that the block's
	// queue fills and it has to stall its input.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Monitor: at each rising edge checks an accepted report against the oldest
	// expectation, then predicts from an accepted input transaction. The report is
	// checked first, since a report can never stem from the transaction accepted at
	// the same edge.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got_report.status = status_t'(status);
				got_report.htype = header_type;
				got_report.pos = position;
				got_report.marker = end_marker;
				if (expected_reports.size() == 0) begin
					err_count++;
					if (err_count <= MAX_SHOWN)
						$display("%0t: report with none expected: st=%0d type=%02h pos=%08h mk=%0d",
							$time, got_report.status, got_report.htype, got_report.pos,
							got_report.marker);
				end else begin
					want_report = expected_reports.pop_front();
					if (got_report.status !== want_report.status ||
							got_report.htype !== want_report.htype ||
							got_report.pos !== want_report.pos ||
							got_report.marker !== want_report.marker) begin
						err_count++;
						if (err_count <= MAX_SHOWN)
							$display({"%0t: report mismatch: expected st=%0d type=%02h pos=%08h",
								" mk=%0d, got st=%0d type=%02h pos=%08h mk=%0d"}, $time,
								want_report.status, want_report.htype, want_report.pos,
								want_report.marker, got_report.status, got_report.htype,
								got_report.pos, got_report.marker);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				ctl_escaped = cfg_data;
				cfg_taken = 1'b1;
			end
			if (in_valid && in_ready) begin
				if (decode_line_item(mode, line_byte, timed_out, next_report))
					expected_reports.push_back(next_report);
				accepted_count++;
				line_taken = 1'b1;
			end
			if ((out_valid && out_ready) || (cfg_valid && cfg_ready) || (in_valid && in_ready))
				quiet_cycles = 0;
			else
				quiet_cycles = quiet_cycles + 1;
		end
	end

	// Watchdog: the run is abandoned if no transaction moves for too long.
	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		int ph, flip;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		write_escape_ctl(1'b0);

		// Directed opening, with no idling on either side. First traffic that must
		// be ignored: the undefined mode, then a timeout and a byte with no header open.
		push_item(MODE_IGNORED, 8'hFF, 1'b1);
		push_item(MODE_BYTE, 8'h00, 1'b1);
		push_item(MODE_BYTE, 8'h55, 1'b0);
		// A good CRC-32 header whose fields need escapes and may be sent with rubout codes.
		push_header(1'b1, END_GOOD, 8'hFF, 32'h1100_FF18);
		// ZDLE and four CANs abort.
		push_item(MODE_BEGIN16, 8'h00, 1'b0);
		push_item(MODE_BYTE, ZDLE_CHAR, 1'b0);
		repeat (4) push_item(MODE_BYTE, CAN_CHAR, 1'b0);
		// A frame-end marker after the type byte.
		push_item(MODE_BEGIN32, 8'hFF, 1'b1);
		push_item(MODE_BYTE, 8'h41, 1'b0);
		push_item(MODE_BYTE, ZDLE_CHAR, 1'b0);
		push_item(MODE_BYTE, ZCRCE_CHAR + 8'd3, 1'b0);
		// A begin while a header is open starts again; then a timeout ends it.
		push_item(MODE_BEGIN16, 8'h00, 1'b0);
		push_item(MODE_BEGIN32, 8'h00, 1'b0);
		push_item(MODE_BYTE, 8'h00, 1'b1);
		// An escape that means nothing.
		push_item(MODE_BEGIN16, 8'h00, 1'b0);
		push_item(MODE_BYTE, ZDLE_CHAR, 1'b0);
		push_item(MODE_BYTE, 8'h20, 1'b0);
		settle_block();

		// Random part: four idling patterns, each run with control escaping on and
		// off. Every phase ends with the sender paused until all reports are in.
		for (ph = 0; ph < 4; ph++) begin
			for (flip = 0; flip < 2; flip++) begin
				write_escape_ctl(flip == 0);
				case (ph)
					0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
					1: begin snd_idle_pct = 69; rcv_stall_pct = 0;  end
					2: begin snd_idle_pct = 0;  rcv_stall_pct = 69; end
					default: begin snd_idle_pct = 28; rcv_stall_pct = 28; end
				endcase
				if (ph == 0 && flip == 0)
					hold_req = 1'b1;
				push_random_traffic(CHUNK_ITEMS);
				settle_block();
			end
		end

		if (err_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> zmodem_binary_header_receiver.f
rtl/zbhr_pkg.sv
rtl/zbhr_front.sv
rtl/zbhr_queue.sv
rtl/zbhr_back.sv
rtl/zmodem_binary_header_receiver.sv
dv/tb_zmodem_binary_header_receiver.sv
